// File: rtl/core/llc_pkg.sv
// ----------------------------------------------------------------------------
// Log line level counter package
// Widths, byte codes, tag words, category and register codes, and the
// payload types carried on the block's channels.
// ----------------------------------------------------------------------------
package llc_pkg;

    localparam int COUNT_WIDTH    = 32;
    localparam int POSITION_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int TAG_LEN        = 5;
    localparam int TAG_SEEN_WIDTH = 3;
    localparam int NUM_CATEGORIES = 5;

    localparam logic [7:0] NL_BYTE      = 8'h0A;
    localparam logic [7:0] CR_BYTE      = 8'h0D;
    localparam logic [7:0] BRACKET_BYTE = 8'h5B;

    localparam logic [39:0] TAG_INFO  = 40'h494E464F2D;
    localparam logic [39:0] TAG_WARN  = 40'h5741524E2D;
    localparam logic [39:0] TAG_ERROR = 40'h4552524F52;
    localparam logic [39:0] TAG_OTHER = 40'h4F54484552;

    localparam logic [2:0] CAT_INFO    = 3'd0;
    localparam logic [2:0] CAT_WARN    = 3'd1;
    localparam logic [2:0] CAT_ERROR   = 3'd2;
    localparam logic [2:0] CAT_OTHER   = 3'd3;
    localparam logic [2:0] CAT_UNKNOWN = 3'd4;

    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_END  = 1'b1;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_LINE_LENGTH = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TAG_OFFSET      = 8'd1;

    localparam logic [7:0] MIN_LINE_LENGTH_RESET = 8'd30;
    localparam logic [7:0] TAG_OFFSET_RESET      = 8'd21;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic                   line_ended;
        logic                   line_valid;
        logic [2:0]             category;
        logic [COUNT_WIDTH-1:0] info_count;
        logic [COUNT_WIDTH-1:0] warn_count;
        logic [COUNT_WIDTH-1:0] error_count;
        logic [COUNT_WIDTH-1:0] other_count;
        logic [COUNT_WIDTH-1:0] unknown_count;
    } out_item_t;

    typedef struct packed {
        logic [CFG_INDEX_WIDTH-1:0] index;
        logic [7:0]                 wdata;
    } cfg_req_t;

endpackage

// File: rtl/core/llc_if.sv
// ----------------------------------------------------------------------------
// Log line level counter channels
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface llc_in_if;
    import llc_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface llc_out_if;
    import llc_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface llc_cfg_if;
    import llc_pkg::*;

    logic     valid;
    logic     ready;
    cfg_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/log_line_level_counter.sv
// ----------------------------------------------------------------------------
// Log line level counter
// Each result is registered in the output slot, or in the spare slot while
// the output is held. Throughput: one request per cycle while the spare
// slot is empty; line state and counters update in the accepting cycle,
// and a two-deep result stage absorbs output stalls. Reset clears the line
// state, counters and both result slots; min length 30, tag offset 21.
// ----------------------------------------------------------------------------
module log_line_level_counter (
    input  logic               clk,
    input  logic               rst_n,
    llc_in_if.sink             item,
    llc_out_if.source          result,
    llc_cfg_if.sink            cfg
);
    import llc_pkg::*;

    localparam int EXT_WIDTH = POSITION_WIDTH + 1;

    logic [7:0]                min_len_reg;
    logic [7:0]                tag_offset_reg;
    logic [POSITION_WIDTH-1:0] pos_reg,     pos_next;
    logic                      bracket_reg, bracket_next;
    logic                      last_cr_reg, last_cr_next;
    logic [39:0]               tag_reg,     tag_next;
    logic [TAG_SEEN_WIDTH-1:0] seen_reg,    seen_next;
    logic [NUM_CATEGORIES-1:0][COUNT_WIDTH-1:0] count_reg, count_next;

    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      skid_valid_reg;
    out_item_t skid_data_reg;

    logic                      accept;
    logic                      out_free;
    logic                      is_nl;
    logic                      close;
    logic [POSITION_WIDTH-1:0] len;
    logic                      ended;
    logic                      valid_line;
    logic [2:0]                cat;
    logic [EXT_WIDTH-1:0]      tag_pos;
    logic [EXT_WIDTH-1:0]      tag_end;
    logic                      pos_max;
    out_item_t                 new_item;

    assign cfg.ready  = 1'b1;
    assign item.ready = !skid_valid_reg;
    assign accept     = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;

    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            min_len_reg    <= MIN_LINE_LENGTH_RESET;
            tag_offset_reg <= TAG_OFFSET_RESET;
        end
        else if (cfg.valid) begin
            unique case (cfg.payload.index)
                CFG_MIN_LINE_LENGTH: min_len_reg    <= cfg.payload.wdata;
                CFG_TAG_OFFSET:      tag_offset_reg <= cfg.payload.wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        is_nl   = (item.payload.mode == MODE_DATA) && (item.payload.data_byte == NL_BYTE);
        close   = (item.payload.mode == MODE_END) ? (pos_reg != '0) : is_nl;
        len     = pos_reg - POSITION_WIDTH'((pos_reg != '0) && last_cr_reg);
        ended   = close && (len != '0);
        valid_line = ended && (len >= POSITION_WIDTH'(min_len_reg)) && bracket_reg;
        tag_end = EXT_WIDTH'(tag_offset_reg) + EXT_WIDTH'(TAG_LEN);
        tag_pos = EXT_WIDTH'(tag_offset_reg) + EXT_WIDTH'(seen_reg);
        pos_max = (pos_reg == {POSITION_WIDTH{1'b1}});

        cat = CAT_UNKNOWN;
        if (seen_reg == TAG_SEEN_WIDTH'(TAG_LEN) && tag_end <= EXT_WIDTH'(len)) begin
            if (tag_reg == TAG_INFO) begin
                cat = CAT_INFO;
            end
            else if (tag_reg == TAG_WARN) begin
                cat = CAT_WARN;
            end
            else if (tag_reg == TAG_ERROR) begin
                cat = CAT_ERROR;
            end
            else if (tag_reg == TAG_OTHER) begin
                cat = CAT_OTHER;
            end
        end
        if (!valid_line) begin
            cat = CAT_INFO;
        end

        pos_next     = pos_reg;
        bracket_next = bracket_reg;
        last_cr_next = last_cr_reg;
        tag_next     = tag_reg;
        seen_next    = seen_reg;
        if (close) begin
            pos_next     = '0;
            bracket_next = 1'b0;
            last_cr_next = 1'b0;
            tag_next     = '0;
            seen_next    = '0;
        end
        else if (item.payload.mode == MODE_DATA) begin
            if (pos_reg == '0) begin
                bracket_next = (item.payload.data_byte == BRACKET_BYTE);
            end
            if (seen_reg < TAG_SEEN_WIDTH'(TAG_LEN) && EXT_WIDTH'(pos_reg) == tag_pos) begin
                tag_next  = {tag_reg[31:0], item.payload.data_byte};
                seen_next = seen_reg + 1'b1;
            end
            last_cr_next = (item.payload.data_byte == CR_BYTE);
            if (!pos_max) begin
                pos_next = pos_reg + 1'b1;
            end
        end

        for (int i = 0; i < NUM_CATEGORIES; i++) begin
            count_next[i] = count_reg[i] +
                COUNT_WIDTH'(valid_line && (cat == 3'(i)));
        end

        new_item.line_ended    = ended;
        new_item.line_valid    = valid_line;
        new_item.category      = cat;
        new_item.info_count    = count_next[CAT_INFO];
        new_item.warn_count    = count_next[CAT_WARN];
        new_item.error_count   = count_next[CAT_ERROR];
        new_item.other_count   = count_next[CAT_OTHER];
        new_item.unknown_count = count_next[CAT_UNKNOWN];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg     <= '0;
            bracket_reg <= 1'b0;
            last_cr_reg <= 1'b0;
            tag_reg     <= '0;
            seen_reg    <= '0;
            count_reg   <= '0;
        end
        else if (accept) begin
            pos_reg     <= pos_next;
            bracket_reg <= bracket_next;
            last_cr_reg <= last_cr_next;
            tag_reg     <= tag_next;
            seen_reg    <= seen_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else begin
                out_valid_reg <= accept;
            end
        end
        else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end
            else if (accept) begin
                out_data_reg <= new_item;
            end
        end
        else if (accept) begin
            skid_data_reg <= new_item;
        end
    end

    // The spare slot is only ever filled behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds a request with the output slot empty");

    // Every accepted request leaves a result in one of the two slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted request produced no result");

    // A request that does not complete a log line leaves the counters alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !valid_line) |=> $stable(count_reg))
        else $error("counters moved without a log line");

    // A newline always starts a fresh line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_nl) |=> (pos_reg == '0 && seen_reg == '0))
        else $error("line state not cleared after newline");

    // The tag capture never runs past five bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (seen_reg <= TAG_SEEN_WIDTH'(TAG_LEN)))
        else $error("tag byte count overran");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log line level counter testbench
// Streams text bytes and end-of-data requests into the block under several
// register settings. Each request is predicted in SystemVerilog: line state,
// tag capture, classification and per-level totals. Every result is compared
// field by field with the oldest prediction. Both channels idle at random,
// one phase runs without idling, and the receiver holds off for a long
// stretch in another.
// ----------------------------------------------------------------------------
module testbench;
    import llc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 50000;

    logic clk;
    logic rst_n;

    llc_in_if  req_ch ();
    llc_out_if res_ch ();
    llc_cfg_if cfg_ch ();

    log_line_level_counter uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (req_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    in_item_t  pending_bytes [$];
    out_item_t expected_reports [$];

    bit          quiet_mode;
    int unsigned hold_off_left;
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned accepted_count;
    int unsigned queued_total;
    int unsigned lines_closed;
    int unsigned log_lines;
    int unsigned settings_used;

    logic [7:0]                min_len_reg;
    logic [7:0]                tag_off_reg;
    logic [POSITION_WIDTH-1:0] line_pos;
    logic                      bracket_first;
    logic                      cr_last;
    logic [39:0]               tag_shift;
    int unsigned               tag_seen;
    logic [COUNT_WIDTH-1:0]    level_totals [NUM_CATEGORIES];

    always #10 clk = ~clk;

    function automatic out_item_t classify_request(in_item_t req);
        out_item_t   res;
        logic        closing;
        int unsigned stripped;
        logic [2:0]  level;
        res = '0;
        closing = 1'b0;
        if (req.mode == MODE_END) begin
            closing = (line_pos != 0);
        end
        else if (req.data_byte == NL_BYTE) begin
            closing = 1'b1;
        end
        else begin
            if (line_pos == 0)
                bracket_first = (req.data_byte == BRACKET_BYTE);
            if (tag_seen < TAG_LEN && line_pos == tag_off_reg + tag_seen) begin
                tag_shift = {tag_shift[31:0], req.data_byte};
                tag_seen++;
            end
            cr_last = (req.data_byte == CR_BYTE);
            if (line_pos != {POSITION_WIDTH{1'b1}})
                line_pos++;
        end
        if (closing) begin
            stripped = 32'(line_pos);
            if (stripped > 0 && cr_last)
                stripped--;
            if (stripped > 0) begin
                res.line_ended = 1'b1;
                lines_closed++;
                if (stripped >= min_len_reg && bracket_first) begin
                    res.line_valid = 1'b1;
                    log_lines++;
                    level = CAT_UNKNOWN;
                    if (tag_seen == TAG_LEN && tag_off_reg + TAG_LEN <= stripped) begin
                        case (tag_shift)
                            TAG_INFO:  level = CAT_INFO;
                            TAG_WARN:  level = CAT_WARN;
                            TAG_ERROR: level = CAT_ERROR;
                            TAG_OTHER: level = CAT_OTHER;
                            default:   level = CAT_UNKNOWN;
                        endcase
                    end
                    res.category = level;
                    level_totals[level]++;
                end
            end
            line_pos = '0;
            bracket_first = 1'b0;
            cr_last = 1'b0;
            tag_shift = '0;
            tag_seen = 0;
        end
        res.info_count    = level_totals[CAT_INFO];
        res.warn_count    = level_totals[CAT_WARN];
        res.error_count   = level_totals[CAT_ERROR];
        res.other_count   = level_totals[CAT_OTHER];
        res.unknown_count = level_totals[CAT_UNKNOWN];
        return res;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        logic taken;
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end
        else begin
            taken = req_ch.valid && req_ch.ready;
            if (taken) begin
                expected_reports.push_back(classify_request(req_ch.payload));
                void'(pending_bytes.pop_front());
                accepted_count++;
            end
            if (!req_ch.valid || taken) begin
                if (pending_bytes.size() != 0 && (quiet_mode || $urandom_range(99) >= 31)) begin
                    req_ch.valid   <= 1'b1;
                    req_ch.payload <= pending_bytes[0];
                end
                else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end
        else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result received with no request outstanding");
                    mismatch_count++;
                end
                else begin
                    want = expected_reports.pop_front();
                    compare_field("line_ended", 32'(want.line_ended),
                                  32'(res_ch.payload.line_ended));
                    compare_field("line_valid", 32'(want.line_valid),
                                  32'(res_ch.payload.line_valid));
                    compare_field("category", 32'(want.category),
                                  32'(res_ch.payload.category));
                    compare_field("info_count", want.info_count, res_ch.payload.info_count);
                    compare_field("warn_count", want.warn_count, res_ch.payload.warn_count);
                    compare_field("error_count", want.error_count,
                                  res_ch.payload.error_count);
                    compare_field("other_count", want.other_count,
                                  res_ch.payload.other_count);
                    compare_field("unknown_count", want.unknown_count,
                                  res_ch.payload.unknown_count);
                end
            end
            res_ch.ready <= (hold_off_left == 0) && (quiet_mode || $urandom_range(99) >= 31);
        end
    end

    always @(posedge clk) begin
        if (hold_off_left > 0)
            hold_off_left <= hold_off_left - 1;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic push_item(logic m, logic [7:0] b);
        in_item_t req;
        req.mode = m;
        req.data_byte = b;
        pending_bytes.push_back(req);
        queued_total++;
    endtask

    task automatic push_text(string s);
        int unsigned k;
        for (k = 0; k < s.len(); k++)
            push_item(MODE_DATA, s[k]);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == NL_BYTE);
        return b;
    endfunction

    task automatic write_register(logic [CFG_INDEX_WIDTH-1:0] idx, logic [7:0] value);
        cfg_req_t req;
        req.index = idx;
        req.wdata = value;
        @(posedge clk);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= req;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_MIN_LINE_LENGTH: min_len_reg = value;
            CFG_TAG_OFFSET:      tag_off_reg = value;
            default:             ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_levels(logic [7:0] min_len, logic [7:0] offset);
        write_register(CFG_MIN_LINE_LENGTH, min_len);
        write_register(CFG_TAG_OFFSET, offset);
        settings_used++;
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || expected_reports.size() != 0 || req_ch.valid)
            @(negedge clk);
    endtask

    task automatic queue_random_line();
        int unsigned shape;
        int unsigned cut;
        int unsigned tail;
        int unsigned k;
        logic [39:0] tag;
        shape = $urandom_range(99);
        if (shape < 8)
            push_item(MODE_DATA, text_byte());
        else
            push_item(MODE_DATA, BRACKET_BYTE);
        for (k = 1; k < tag_off_reg; k++)
            push_item(MODE_DATA, text_byte());
        case ($urandom_range(5))
            0:       tag = TAG_INFO;
            1:       tag = TAG_WARN;
            2:       tag = TAG_ERROR;
            3:       tag = TAG_OTHER;
            4:       tag = {$urandom, 8'($urandom)};
            default: tag = TAG_WARN ^ (40'h1 << $urandom_range(39));
        endcase
        cut = (shape >= 8 && shape < 16) ? $urandom_range(4) : TAG_LEN;
        for (k = 0; k < cut; k++)
            push_item(MODE_DATA, tag[39 - 8 * k -: 8]);
        tail = 0;
        if (cut == TAG_LEN)
            tail = $urandom_range(0, (min_len_reg > tag_off_reg + TAG_LEN) ?
                                     min_len_reg - tag_off_reg - TAG_LEN + 8 : 8);
        for (k = 0; k < tail; k++)
            push_item(MODE_DATA, text_byte());
        if ($urandom_range(3) == 0)
            push_item(MODE_DATA, CR_BYTE);
        if ($urandom_range(9) == 0)
            push_item(MODE_END, 8'($urandom));
        else
            push_item(MODE_DATA, NL_BYTE);
    endtask

    task automatic queue_noise();
        int unsigned n;
        int unsigned k;
        n = $urandom_range(1, 20);
        for (k = 0; k < n; k++)
            push_item($urandom_range(9) == 0 ? MODE_END : MODE_DATA, 8'($urandom));
    endtask

    task automatic fill_phase(int unsigned budget);
        int unsigned start;
        start = queued_total;
        while (queued_total - start < budget) begin
            if ($urandom_range(9) == 0)
                queue_noise();
            else
                queue_random_line();
        end
    endtask

    initial begin
        int unsigned k;
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        min_len_reg = MIN_LINE_LENGTH_RESET;
        tag_off_reg = TAG_OFFSET_RESET;
        line_pos = '0;
        bracket_first = 1'b0;
        cr_last = 1'b0;
        tag_shift = '0;
        tag_seen = 0;
        for (k = 0; k < NUM_CATEGORIES; k++)
            level_totals[k] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Short lines under a small minimum cover each level and each way a
        // line can close or be rejected.
        set_levels(8'd4, 8'd1);
        push_text("[INFO-");
        push_item(MODE_DATA, NL_BYTE);
        push_text("[WARN-");
        push_item(MODE_DATA, CR_BYTE);
        push_item(MODE_DATA, NL_BYTE);
        push_text("[ERROR");
        push_item(MODE_END, 8'hFF);
        push_item(MODE_END, 8'h00);
        push_item(MODE_DATA, NL_BYTE);
        push_item(MODE_DATA, CR_BYTE);
        push_item(MODE_DATA, NL_BYTE);
        push_text("[OTHER");
        push_item(MODE_DATA, NL_BYTE);
        push_text("[a");
        push_item(MODE_DATA, NL_BYTE);
        push_text("[INF");
        push_item(MODE_DATA, NL_BYTE);
        push_item(MODE_DATA, 8'h00);
        push_item(MODE_DATA, 8'hFF);
        push_item(MODE_DATA, NL_BYTE);
        push_text("[?????");
        push_item(MODE_END, 8'h5A);
        wait_drained();

        set_levels(8'd1, 8'd1);
        quiet_mode = 1'b1;
        fill_phase(300);
        wait_drained();
        quiet_mode = 1'b0;

        set_levels(8'd255, 8'd250);
        fill_phase(250);
        wait_drained();

        set_levels(8'($urandom_range(10, 60)), 8'($urandom_range(2, 40)));
        fill_phase(300);
        hold_off_left = 250;
        wait_drained();

        set_levels(8'($urandom_range(1, 80)), 8'($urandom_range(1, 60)));
        fill_phase(250);
        wait_drained();

        repeat (8) @(negedge clk);
        $display("testbench: %0d requests under %0d register settings", accepted_count,
                 settings_used);
        $display("testbench: %0d lines closed, %0d of them log lines", lines_closed, log_lines);
        if (mismatch_count == 0 && expected_reports.size() == 0) begin
            $display("testbench: done, clean");
        end
        else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/llc_pkg.sv
rtl/core/llc_if.sv
rtl/core/log_line_level_counter.sv
tb/testbench.sv
